// ----- sv/mlpfb_pkg.sv -----
// Shared types, codes and the sigmoid table builder for the perceptron core.
package mlpfb_pkg;

    localparam int DATA_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;
    localparam int LAYER_CAP  = 4;
    localparam int NEURON_CAP = 16;

    localparam logic [1:0] OP_WEIGHT   = 2'd0;
    localparam logic [1:0] OP_INFER    = 2'd1;
    localparam logic [1:0] OP_TRAIN_IN = 2'd2;
    localparam logic [1:0] OP_TARGET   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_LAYER_COUNT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_ZERO     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_ONE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_TWO      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_THREE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LEARNING_RATE = 3'd5;

    localparam longint Q30 = longint'(1) << 30;

    typedef enum logic [4:0] {
        S_IDLE,
        S_F_RD, S_F_MUL, S_F_ACC, S_F_SIG, S_F_WR,
        S_O_RD, S_O_LD, S_O_WAIT,
        S_T_RD, S_T_G, S_T_M, S_T_W,
        S_H_RD, S_H_MUL, S_H_ACC, S_H_G, S_H_M, S_H_W,
        S_U_RD, S_U_M1, S_U_M2, S_U_W
    } t_state;

    function automatic longint unsigned udiv(input longint unsigned a,
                                             input longint unsigned b);
        longint unsigned q;
        longint unsigned rem;
        q   = '0;
        rem = '0;
        for (int n = 63; n >= 0; n--) begin
            rem = {rem[62:0], a[n]};
            if (rem >= b) begin
                rem  = rem - b;
                q[n] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [15:0] sig_entry(input int depth, input int k);
        longint h;
        longint term;
        longint r;
        longint p;
        longint den;
        int     m;
        h    = longint'(udiv(64'd8 << 30, 64'(depth)));
        term = Q30;
        r    = Q30;
        p    = Q30;
        for (int n = 1; n <= 24; n++) begin
            term = longint'(udiv(64'((term * h) >>> 30), 64'(n)));
            if ((n & 1) == 1) begin
                r = r - term;
            end else begin
                r = r + term;
            end
        end
        if (2 * k >= depth - 1) begin
            m = 2 * k - depth + 1;
        end else begin
            m = depth - 1 - 2 * k;
        end
        for (int s = 0; s < m; s++) begin
            p = (p * r) >>> 30;
        end
        den = Q30 + p;
        if (2 * k >= depth - 1) begin
            return 16'(udiv(64'((longint'(1) << 42) + (den >>> 1)), 64'(den)));
        end
        return 16'(udiv(64'((p << 12) + (den >>> 1)), 64'(den)));
    endfunction

endpackage

// ----- sv/mlpfb_ifs.sv -----
// Channel interfaces: input items, result items and configuration writes.
interface mlpfb_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         operation;
    logic [1:0]         weight_block;
    logic [3:0]         row_index;
    logic [3:0]         column_index;
    logic signed [15:0] data_value;
    logic               last_element;
    modport source(output valid, operation, weight_block, row_index, column_index,
                   data_value, last_element, input ready);
    modport sink(input valid, operation, weight_block, row_index, column_index,
                 data_value, last_element, output ready);
endinterface

interface mlpfb_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] output_value;
    logic [3:0]         output_position;
    logic               last_output;
    modport source(output valid, output_value, output_position, last_output, input ready);
    modport sink(input valid, output_value, output_position, last_output, output ready);
endinterface

interface mlpfb_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [11:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// ----- sv/mlp_forward_and_backprop_core.sv -----
// Top level: sigmoid perceptron with one shared multiply-accumulate under a sequencer.
//
// Input channel i_in takes weight writes, input elements and target elements.
// Weight writes and elements that are not marked last are taken while idle.
// An inference element marked last starts a forward pass, after which the
// output vector leaves on o_out, one transfer per output neuron, lowest first.
// A target element marked last starts a forward pass, backpropagation and a
// weight update; training produces no transfers on o_out.
// A forward pass reads, multiplies and accumulates each weight, then applies the
// sigmoid table and writes each neuron's activation. Training then computes the
// output-layer deltas, carries deltas back through each hidden layer and updates
// every weight through the single multiplier. i_in is not ready while a pass
// runs or a result waits. A stalled o_out holds its result in the output
// register until the transfer completes. Configuration writes on i_cfg are
// always taken. Synchronous reset restores the register defaults and clears
// the input layer; weights and targets hold no defined value until written.
module mlp_forward_and_backprop_core #(
    parameter int MAX_LAYERS          = 4,
    parameter int MAX_NEURONS         = 16,
    parameter int SIGMOID_TABLE_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mlpfb_in_if.sink    i_in,
    mlpfb_out_if.source o_out,
    mlpfb_cfg_if.sink   i_cfg
);
    import mlpfb_pkg::*;

    localparam int LLIM   = (MAX_LAYERS < LAYER_CAP) ? MAX_LAYERS : LAYER_CAP;
    localparam int NLIM   = (MAX_NEURONS < NEURON_CAP) ? MAX_NEURONS : NEURON_CAP;
    localparam int WDEPTH = (MAX_LAYERS - 1) * MAX_NEURONS * MAX_NEURONS;
    localparam int ADEPTH = MAX_LAYERS * MAX_NEURONS;
    localparam int DDEPTH = (MAX_LAYERS - 1) * MAX_NEURONS;
    localparam int TDEPTH = MAX_NEURONS;
    localparam int WAW    = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
    localparam int AAW    = (ADEPTH > 1) ? $clog2(ADEPTH) : 1;
    localparam int DAW    = (DDEPTH > 1) ? $clog2(DDEPTH) : 1;
    localparam int TAW    = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;
    localparam int RIW    = $clog2(SIGMOID_TABLE_DEPTH);

    t_state r_state, n_state;
    logic [1:0]  r_l, n_l;
    logic [3:0]  r_i, n_i;
    logic [3:0]  r_j, n_j;
    logic signed [39:0] r_acc, n_acc;
    logic signed [53:0] r_prod, n_prod;
    logic [RIW-1:0] r_idx, n_idx;
    logic r_train, n_train;
    logic r_out_valid, n_out_valid;
    logic signed [15:0] r_out_value, n_out_value;
    logic [3:0]  r_out_pos, n_out_pos;
    logic        r_out_last, n_out_last;

    logic [2:0]  r_layer_count;
    logic [4:0]  r_size [4];
    logic [11:0] r_rate;

    logic signed [15:0] r_wmem [WDEPTH];
    logic signed [15:0] r_amem [ADEPTH];
    logic signed [15:0] r_dmem [DDEPTH];
    logic signed [15:0] r_tmem [TDEPTH];
    logic [NEURON_CAP-1:0] r_vld;
    logic signed [15:0] r_w_q, r_act_q, r_dl_q, r_tg_q;
    logic r_act_vq;

    logic [WAW-1:0] w_w_raddr, w_w_waddr;
    logic [AAW-1:0] w_a_raddr, w_a_waddr;
    logic [DAW-1:0] w_d_raddr, w_d_waddr;
    logic [TAW-1:0] w_t_waddr;
    logic [1:0]  w_ar_l;
    logic [3:0]  w_ar_n;
    logic w_w_we, w_a_we, w_d_we, w_t_we;
    logic signed [15:0] w_w_wdata, w_a_wdata, w_d_wdata;
    logic signed [15:0] w_act;
    logic signed [32:0] w_ma;
    logic signed [20:0] w_mb;
    logic signed [53:0] w_prod;
    logic [2:0]  w_nl;
    logic [1:0]  w_last;
    logic signed [39:0] w_s;
    logic signed [15:0] w_v;
    logic [31:0] w_sig_prod;
    logic [15:0] w_rom [SIGMOID_TABLE_DEPTH];

    for (genvar k = 0; k < SIGMOID_TABLE_DEPTH; k++) begin : g_rom
        assign w_rom[k] = sig_entry(SIGMOID_TABLE_DEPTH, k);
    end

    function automatic logic [3:0] sz_m1(input logic [1:0] l);
        logic [4:0] n;
        n = r_size[l];
        if (n == 5'd0) begin
            return 4'd0;
        end
        if (int'(n) > NLIM) begin
            return 4'(NLIM - 1);
        end
        return 4'(n - 5'd1);
    endfunction

    function automatic logic [WAW-1:0] widx(input logic [1:0] b, input logic [3:0] s,
                                            input logic [3:0] d);
        return WAW'((int'(b) * MAX_NEURONS + int'(s)) * MAX_NEURONS + int'(d));
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [53:0] v);
        if (v > 54'sd32767) begin
            return 16'sh7fff;
        end
        if (v < -54'sd32768) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    always_comb begin
        if (r_layer_count < 3'd2) begin
            w_nl = 3'd2;
        end else if (int'(r_layer_count) > LLIM) begin
            w_nl = 3'(LLIM);
        end else begin
            w_nl = r_layer_count;
        end
    end
    assign w_last = 2'(w_nl - 3'd1);

    assign w_act  = r_act_vq ? r_act_q : 16'sd0;
    assign w_prod = w_ma * w_mb;

    assign w_s        = r_acc >>> 12;
    assign w_v        = (w_s > 40'sd32767) ? 16'sh7fff :
                        (w_s < -40'sd32768) ? 16'sh8000 : w_s[15:0];
    assign w_sig_prod = 32'({~w_v[15], w_v[14:0]}) * 32'(SIGMOID_TABLE_DEPTH);

    always_comb begin
        w_ar_l    = r_l;
        w_ar_n    = r_i;
        w_w_raddr = widx(r_l, r_i, r_j);
        w_d_raddr = DAW'(int'(r_l) * MAX_NEURONS + int'(r_j));
        unique case (r_state)
            S_F_RD, S_F_MUL, S_F_ACC, S_F_SIG, S_F_WR: begin
                w_ar_l    = r_l - 2'd1;
                w_w_raddr = widx(r_l - 2'd1, r_i, r_j);
            end
            S_O_RD, S_O_LD, S_O_WAIT, S_T_RD, S_T_G, S_T_M, S_T_W: begin
                w_ar_l = w_last;
                w_ar_n = r_j;
            end
            S_H_RD, S_H_MUL, S_H_ACC, S_H_G, S_H_M, S_H_W: begin
                w_ar_n    = r_j;
                w_w_raddr = widx(r_l, r_j, r_i);
                w_d_raddr = DAW'(int'(r_l) * MAX_NEURONS + int'(r_i));
            end
            default: begin
            end
        endcase
        w_a_raddr = AAW'(int'(w_ar_l) * MAX_NEURONS + int'(w_ar_n));
    end

    always_comb begin
        n_state     = r_state;
        n_l         = r_l;
        n_i         = r_i;
        n_j         = r_j;
        n_acc       = r_acc;
        n_prod      = r_prod;
        n_idx       = r_idx;
        n_train     = r_train;
        n_out_valid = r_out_valid;
        n_out_value = r_out_value;
        n_out_pos   = r_out_pos;
        n_out_last  = r_out_last;
        w_ma        = '0;
        w_mb        = '0;
        w_w_we      = 1'b0;
        w_a_we      = 1'b0;
        w_d_we      = 1'b0;
        w_t_we      = 1'b0;
        w_w_waddr   = widx(r_l, r_i, r_j);
        w_w_wdata   = sat16(54'(r_w_q) + (r_prod >>> 24));
        w_a_waddr   = AAW'(int'(r_l) * MAX_NEURONS + int'(r_j));
        w_a_wdata   = w_rom[r_idx];
        w_d_waddr   = DAW'(int'(r_l - 2'd1) * MAX_NEURONS + int'(r_j));
        w_d_wdata   = sat16(r_prod >>> 12);
        w_t_waddr   = TAW'(i_in.row_index);
        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    unique case (i_in.operation) inside
                        OP_WEIGHT: begin
                            w_w_waddr = widx(i_in.weight_block, i_in.row_index,
                                             i_in.column_index);
                            w_w_wdata = i_in.data_value;
                            w_w_we    = (int'(i_in.weight_block) < MAX_LAYERS - 1) &&
                                        (int'(i_in.row_index) < MAX_NEURONS) &&
                                        (int'(i_in.column_index) < MAX_NEURONS);
                        end
                        OP_INFER, OP_TRAIN_IN: begin
                            w_a_waddr = AAW'(i_in.row_index);
                            w_a_wdata = i_in.data_value;
                            w_a_we    = (i_in.row_index <= sz_m1(2'd0));
                            if (i_in.last_element && i_in.operation == OP_INFER) begin
                                n_train = 1'b0;
                                n_state = S_F_RD;
                                n_l     = 2'd1;
                                n_i     = '0;
                                n_j     = '0;
                                n_acc   = '0;
                            end
                        end
                        OP_TARGET: begin
                            w_t_we = (i_in.row_index <= sz_m1(w_last));
                            if (i_in.last_element) begin
                                n_train = 1'b1;
                                n_state = S_F_RD;
                                n_l     = 2'd1;
                                n_i     = '0;
                                n_j     = '0;
                                n_acc   = '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_F_RD: n_state = S_F_MUL;
            S_F_MUL: begin
                w_ma    = 33'(w_act);
                w_mb    = 21'(r_w_q);
                n_prod  = w_prod;
                n_state = S_F_ACC;
            end
            S_F_ACC: begin
                n_acc = r_acc + $signed(r_prod[39:0]);
                if (r_i == sz_m1(r_l - 2'd1)) begin
                    n_state = S_F_SIG;
                end else begin
                    n_i     = r_i + 4'd1;
                    n_state = S_F_RD;
                end
            end
            S_F_SIG: begin
                n_idx   = w_sig_prod[16 +: RIW];
                n_state = S_F_WR;
            end
            S_F_WR: begin
                w_a_we  = 1'b1;
                n_acc   = '0;
                n_i     = '0;
                n_state = S_F_RD;
                if (r_j == sz_m1(r_l)) begin
                    n_j = '0;
                    if (r_l == w_last) begin
                        n_state = r_train ? S_T_RD : S_O_RD;
                    end else begin
                        n_l = r_l + 2'd1;
                    end
                end else begin
                    n_j = r_j + 4'd1;
                end
            end
            S_O_RD: n_state = S_O_LD;
            S_O_LD: begin
                n_out_valid = 1'b1;
                n_out_value = w_act;
                n_out_pos   = r_j;
                n_out_last  = (r_j == sz_m1(w_last));
                n_state     = S_O_WAIT;
            end
            S_O_WAIT: begin
                if (o_out.ready) begin
                    n_out_valid = 1'b0;
                    if (r_out_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_j     = r_j + 4'd1;
                        n_state = S_O_RD;
                    end
                end
            end
            S_T_RD: n_state = S_T_G;
            S_T_G: begin
                w_ma    = 33'sd4096 - 33'(w_act);
                w_mb    = 21'(w_act);
                n_prod  = w_prod;
                n_state = S_T_M;
            end
            S_T_M: begin
                w_ma    = 33'(r_tg_q) - 33'(w_act);
                w_mb    = $signed(r_prod[32:12]);
                n_prod  = w_prod;
                n_state = S_T_W;
            end
            S_T_W: begin
                w_d_we    = 1'b1;
                w_d_waddr = DAW'(int'(w_last - 2'd1) * MAX_NEURONS + int'(r_j));
                if (r_j == sz_m1(w_last)) begin
                    n_j   = '0;
                    n_i   = '0;
                    n_acc = '0;
                    if (w_last >= 2'd2) begin
                        n_l     = w_last - 2'd1;
                        n_state = S_H_RD;
                    end else begin
                        n_l     = 2'd0;
                        n_state = S_U_RD;
                    end
                end else begin
                    n_j     = r_j + 4'd1;
                    n_state = S_T_RD;
                end
            end
            S_H_RD: n_state = S_H_MUL;
            S_H_MUL: begin
                w_ma    = 33'(r_dl_q);
                w_mb    = 21'(r_w_q);
                n_prod  = w_prod;
                n_state = S_H_ACC;
            end
            S_H_ACC: begin
                n_acc = r_acc + $signed(r_prod[39:0]);
                if (r_i == sz_m1(r_l + 2'd1)) begin
                    n_state = S_H_G;
                end else begin
                    n_i     = r_i + 4'd1;
                    n_state = S_H_RD;
                end
            end
            S_H_G: begin
                w_ma    = 33'sd4096 - 33'(w_act);
                w_mb    = 21'(w_act);
                n_prod  = w_prod;
                n_state = S_H_M;
            end
            S_H_M: begin
                w_ma    = 33'(r_acc >>> 12);
                w_mb    = $signed(r_prod[32:12]);
                n_prod  = w_prod;
                n_state = S_H_W;
            end
            S_H_W: begin
                w_d_we  = 1'b1;
                n_acc   = '0;
                n_i     = '0;
                n_state = S_H_RD;
                if (r_j == sz_m1(r_l)) begin
                    n_j = '0;
                    if (r_l == 2'd1) begin
                        n_l     = 2'd0;
                        n_state = S_U_RD;
                    end else begin
                        n_l = r_l - 2'd1;
                    end
                end else begin
                    n_j = r_j + 4'd1;
                end
            end
            S_U_RD: n_state = S_U_M1;
            S_U_M1: begin
                w_ma    = 33'(w_act);
                w_mb    = 21'(r_dl_q);
                n_prod  = w_prod;
                n_state = S_U_M2;
            end
            S_U_M2: begin
                w_ma    = $signed(r_prod[32:0]);
                w_mb    = $signed({9'd0, r_rate});
                n_prod  = w_prod;
                n_state = S_U_W;
            end
            S_U_W: begin
                w_w_we  = 1'b1;
                n_state = S_U_RD;
                if (r_j == sz_m1(r_l + 2'd1)) begin
                    n_j = '0;
                    if (r_i == sz_m1(r_l)) begin
                        n_i = '0;
                        if (r_l == w_last - 2'd1) begin
                            n_state = S_IDLE;
                        end else begin
                            n_l = r_l + 2'd1;
                        end
                    end else begin
                        n_i = r_i + 4'd1;
                    end
                end else begin
                    n_j = r_j + 4'd1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_train     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_train     <= n_train;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_l         <= n_l;
        r_i         <= n_i;
        r_j         <= n_j;
        r_acc       <= n_acc;
        r_prod      <= n_prod;
        r_idx       <= n_idx;
        r_out_value <= n_out_value;
        r_out_pos   <= n_out_pos;
        r_out_last  <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layer_count <= 3'd3;
            r_size[0]     <= 5'd16;
            r_size[1]     <= 5'd16;
            r_size[2]     <= 5'd16;
            r_size[3]     <= 5'd16;
            r_rate        <= 12'd1024;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_LAYER_COUNT:   r_layer_count <= i_cfg.data[2:0];
                REG_SIZE_ZERO:     r_size[0]     <= i_cfg.data[4:0];
                REG_SIZE_ONE:      r_size[1]     <= i_cfg.data[4:0];
                REG_SIZE_TWO:      r_size[2]     <= i_cfg.data[4:0];
                REG_SIZE_THREE:    r_size[3]     <= i_cfg.data[4:0];
                REG_LEARNING_RATE: r_rate        <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_a_we && r_state == S_IDLE) begin
            r_vld[i_in.row_index] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_w_we) begin
            r_wmem[w_w_waddr] <= w_w_wdata;
        end
        r_w_q <= r_wmem[w_w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_a_we) begin
            r_amem[w_a_waddr] <= w_a_wdata;
        end
        r_act_q  <= r_amem[w_a_raddr];
        r_act_vq <= (w_ar_l != 2'd0) || r_vld[w_ar_n];
    end

    always_ff @(posedge i_clk) begin
        if (w_d_we) begin
            r_dmem[w_d_waddr] <= w_d_wdata;
        end
        r_dl_q <= r_dmem[w_d_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_t_we) begin
            r_tmem[w_t_waddr] <= i_in.data_value;
        end
        r_tg_q <= r_tmem[TAW'(r_j)];
    end

    assign i_in.ready            = (r_state == S_IDLE);
    assign i_cfg.ready           = 1'b1;
    assign o_out.valid           = r_out_valid;
    assign o_out.output_value    = r_out_value;
    assign o_out.output_position = r_out_pos;
    assign o_out.last_output     = r_out_last;

endmodule
